### rtl/mrfm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mrfm_pkg
// Shared widths, register map and reset values of the mains RMS and
// frequency monitor.
// ============================================================================
package mrfm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 16;
    localparam int THR_W    = 20;
    localparam int WLEN_W   = 10;
    localparam int RATE_W   = 17;
    localparam int MINP_W   = 16;
    localparam int CNT_W    = 16;
    localparam int FREQ_W   = 24;
    localparam int SUM_W    = 40;
    localparam int FRAC_W   = 16;
    localparam int MS_W     = SUM_W + FRAC_W;
    localparam int ROOT_W   = MS_W / 2;
    localparam int DIV_DW   = 16;
    localparam int MUL_AW   = ROOT_W;
    localparam int MUL_BW   = GAIN_W;
    localparam int PROD_W   = MUL_AW + MUL_BW;

    localparam int DIV_CNT_W  = $clog2(MS_W);
    localparam int SQRT_CNT_W = $clog2(ROOT_W);
    localparam int MUL_CNT_W  = $clog2(MUL_BW);

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_OFFSET   = 3'd0;
    localparam logic [2:0] REG_GAIN     = 3'd1;
    localparam logic [2:0] REG_LOW_THR  = 3'd2;
    localparam logic [2:0] REG_HIGH_THR = 3'd3;
    localparam logic [2:0] REG_WIN_LEN  = 3'd4;
    localparam logic [2:0] REG_RATE     = 3'd5;
    localparam logic [2:0] REG_MIN_PER  = 3'd6;

    localparam logic [SAMPLE_W-1:0] OFFSET_RST   = 12'd1497;
    localparam logic [GAIN_W-1:0]   GAIN_RST     = 16'd8579;
    localparam logic [THR_W-1:0]    LOW_THR_RST  = 20'd12800;
    localparam logic [THR_W-1:0]    HIGH_THR_RST = 20'd62720;
    localparam logic [WLEN_W-1:0]   WIN_LEN_RST  = 10'd333;
    localparam logic [RATE_W-1:0]   RATE_RST     = 17'd20000;
    localparam logic [MINP_W-1:0]   MIN_PER_RST  = 16'd250;

    typedef struct packed {
        logic [THR_W-1:0]  rms_volts_q8;
        logic              blackout;
        logic              surge;
        logic [FREQ_W-1:0] frequency_centihz;
    } result_t;

endpackage

### rtl/mrfm_serial_mul.sv
`timescale 1ns / 1ps
// ============================================================================
// mrfm_serial_mul
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// ============================================================================
module mrfm_serial_mul import mrfm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MUL_AW-1:0] a_in,
    input  logic [MUL_BW-1:0] b_in,
    output logic              busy,
    output logic [PROD_W-1:0] product
);

    localparam logic [MUL_CNT_W-1:0] LAST = MUL_CNT_W'(MUL_BW - 1);

    logic                 busy_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_AW-1:0]    a_reg;
    logic [MUL_AW-1:0]    acc_reg;
    logic [MUL_BW-1:0]    lo_reg;
    logic [MUL_AW:0]      sum;

    assign sum = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a_in;
            acc_reg <= '0;
            lo_reg  <= b_in;
        end else if (busy_reg) begin
            acc_reg <= sum[MUL_AW:1];
            lo_reg  <= {sum[0], lo_reg[MUL_BW-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign product = {acc_reg, lo_reg};

endmodule

### rtl/mrfm_serial_div.sv
`timescale 1ns / 1ps
// ============================================================================
// mrfm_serial_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ============================================================================
module mrfm_serial_div import mrfm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MS_W-1:0]   num_in,
    input  logic [DIV_DW-1:0] den_in,
    output logic              busy,
    output logic [MS_W-1:0]   quotient
);

    localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(MS_W - 1);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [MS_W-1:0]      num_reg;
    logic [DIV_DW-1:0]    den_reg;
    logic [DIV_DW-1:0]    rem_reg;
    logic [DIV_DW:0]      rem_shift;
    logic [DIV_DW+1:0]    diff;
    logic                 ge;

    assign rem_shift = {rem_reg, num_reg[MS_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign ge        = !diff[DIV_DW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num_in;
            den_reg <= den_in;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[MS_W-2:0], ge};
            rem_reg <= ge ? diff[DIV_DW-1:0] : rem_shift[DIV_DW-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = num_reg;

endmodule

### rtl/mrfm_serial_sqrt.sv
`timescale 1ns / 1ps
// ============================================================================
// mrfm_serial_sqrt
// Floor square root, digit by digit, two radicand bits per cycle.
// ============================================================================
module mrfm_serial_sqrt import mrfm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MS_W-1:0]   rad_in,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    localparam logic [SQRT_CNT_W-1:0] LAST = SQRT_CNT_W'(ROOT_W - 1);

    logic                  busy_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic [MS_W-1:0]       rad_reg;
    logic [ROOT_W+1:0]     rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_W+1:0]     rem_shift;
    logic [ROOT_W+1:0]     trial;
    logic [ROOT_W+2:0]     diff;
    logic                  ge;

    assign rem_shift = {rem_reg[ROOT_W-1:0], rad_reg[MS_W-1:MS_W-2]};
    assign trial     = {root_reg, 2'b01};
    assign diff      = {1'b0, rem_shift} - {1'b0, trial};
    assign ge        = !diff[ROOT_W+2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= rad_in;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[MS_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[ROOT_W+1:0] : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

### rtl/mains_rms_and_frequency_monitor.sv
`timescale 1ns / 1ps
// ============================================================================
// mains_rms_and_frequency_monitor
// Windowed true-RMS voltage with blackout/surge flags and a zero-crossing
// frequency estimate, built around bit-serial multiply, divide and root.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_sample_mv, s_sample_valid
//   m_        out        m_valid/m_ready    m_rms_volts_q8, m_blackout,
//                                           m_surge, m_frequency_centihz
//   apb       in/out     psel/penable       paddr, pwdata, prdata
//
// An invalid sample is dropped and the block stays idle. A valid sample goes
// through the 16-step shift-add squarer; a sample with a rising crossing also
// starts the 56-step divider running alongside. Window end then runs the
// divide, the root and the gain multiply in turn. s_ready is low while
// an item is in work or its result waits for the output register.
// Reset (aresetn low, synchronous) restores register defaults and clears
// the window, crossing counter and frequency estimate.
// ============================================================================
module mains_rms_and_frequency_monitor import mrfm_pkg::*; #(
    parameter int WINDOW_BITS = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample_mv,
    input  logic                s_sample_valid,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [THR_W-1:0]    m_rms_volts_q8,
    output logic                m_blackout,
    output logic                m_surge,
    output logic [FREQ_W-1:0]   m_frequency_centihz,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int WIN_CAP = (1 << WINDOW_BITS) - 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_MS   = 3'd2;
    localparam logic [2:0] S_RT   = 3'd3;
    localparam logic [2:0] S_GM   = 3'd4;

    // configuration
    logic [SAMPLE_W-1:0] offset_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [THR_W-1:0]    low_thr_reg;
    logic [THR_W-1:0]    high_thr_reg;
    logic [WLEN_W-1:0]   win_len_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [MINP_W-1:0]   min_per_reg;
    logic                cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg   <= OFFSET_RST;
            gain_reg     <= GAIN_RST;
            low_thr_reg  <= LOW_THR_RST;
            high_thr_reg <= HIGH_THR_RST;
            win_len_reg  <= WIN_LEN_RST;
            rate_reg     <= RATE_RST;
            min_per_reg  <= MIN_PER_RST;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_OFFSET:   offset_reg   <= pwdata[SAMPLE_W-1:0];
                REG_GAIN:     gain_reg     <= pwdata[GAIN_W-1:0];
                REG_LOW_THR:  low_thr_reg  <= pwdata[THR_W-1:0];
                REG_HIGH_THR: high_thr_reg <= pwdata[THR_W-1:0];
                REG_WIN_LEN:  win_len_reg  <= pwdata[WLEN_W-1:0];
                REG_RATE:     rate_reg     <= pwdata[RATE_W-1:0];
                REG_MIN_PER:  min_per_reg  <= pwdata[MINP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_OFFSET:   prdata = APB_DW'(offset_reg);
            REG_GAIN:     prdata = APB_DW'(gain_reg);
            REG_LOW_THR:  prdata = APB_DW'(low_thr_reg);
            REG_HIGH_THR: prdata = APB_DW'(high_thr_reg);
            REG_WIN_LEN:  prdata = APB_DW'(win_len_reg);
            REG_RATE:     prdata = APB_DW'(rate_reg);
            REG_MIN_PER:  prdata = APB_DW'(min_per_reg);
            default:      prdata = '0;
        endcase
    end

    // datapath state
    logic [2:0]             state_reg;
    logic [WINDOW_BITS-1:0] win_cnt_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   prev_np_reg;
    logic [CNT_W-1:0]       cross_cnt_reg;
    logic [FREQ_W-1:0]      freq_reg;
    logic                   freq_pend_reg;
    logic                   out_valid_reg;
    result_t                out_reg;

    logic                   accept;
    logic                   take;
    logic signed [SAMPLE_W:0] dev;
    logic                   positive;
    logic [SAMPLE_W-1:0]    mag;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   cross_hit;
    logic [FREQ_W-1:0]      rate100;
    logic [WINDOW_BITS-1:0] n_eff;
    logic [WINDOW_BITS-1:0] win_inc;
    logic                   win_end;
    logic [SUM_W-1:0]       sum_next;
    logic                   acc_done;
    logic [MUL_AW-1:0]      scaled;
    logic [THR_W-1:0]       rms;
    logic                   out_free;
    logic                   out_load;

    logic                   mul_start, mul_busy;
    logic [MUL_AW-1:0]      mul_a;
    logic [MUL_BW-1:0]      mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic                   div_start, div_busy;
    logic [MS_W-1:0]        div_num;
    logic [DIV_DW-1:0]      div_den;
    logic [MS_W-1:0]        div_q;
    logic                   sqrt_start, sqrt_busy;
    logic [ROOT_W-1:0]      sqrt_root;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign take     = accept && s_sample_valid;

    assign dev      = $signed({1'b0, s_sample_mv}) - $signed({1'b0, offset_reg});
    assign positive = !dev[SAMPLE_W] && (dev != '0);
    assign mag      = dev[SAMPLE_W] ? SAMPLE_W'(-dev) : dev[SAMPLE_W-1:0];

    assign cnt_inc   = (cross_cnt_reg == '1) ? cross_cnt_reg : cross_cnt_reg + 1'b1;
    assign cross_hit = prev_np_reg && positive && (cnt_inc > min_per_reg);
    assign rate100   = (FREQ_W'(rate_reg) << 6) + (FREQ_W'(rate_reg) << 5)
                     + (FREQ_W'(rate_reg) << 2);

    always_comb begin
        if (win_len_reg == '0) begin
            n_eff = WINDOW_BITS'(1);
        end else if (32'(win_len_reg) > 32'(WIN_CAP)) begin
            n_eff = WINDOW_BITS'(WIN_CAP);
        end else begin
            n_eff = WINDOW_BITS'(win_len_reg);
        end
    end

    assign win_inc  = win_cnt_reg + 1'b1;
    assign win_end  = (win_inc >= n_eff);
    assign sum_next = sum_reg + SUM_W'(mul_p[2*SAMPLE_W-1:0]);
    assign acc_done = (state_reg == S_ACC) && !mul_busy && !div_busy;

    assign scaled   = mul_p[PROD_W-1:FRAC_W];
    assign rms      = (|scaled[MUL_AW-1:THR_W]) ? '1 : scaled[THR_W-1:0];
    assign out_free = !out_valid_reg || m_ready;
    assign out_load = (state_reg == S_GM) && !mul_busy && out_free;

    // unit sequencing: operands come straight from the state that starts them
    assign mul_start  = take || ((state_reg == S_RT) && !sqrt_busy);
    assign mul_a      = (state_reg == S_IDLE) ? MUL_AW'(mag) : sqrt_root;
    assign mul_b      = (state_reg == S_IDLE) ? MUL_BW'(mag) : gain_reg;
    assign div_start  = (take && cross_hit) || (acc_done && win_end);
    assign div_num    = (state_reg == S_IDLE) ? MS_W'(rate100) : {sum_next, FRAC_W'(0)};
    assign div_den    = (state_reg == S_IDLE) ? cnt_inc : DIV_DW'(n_eff);
    assign sqrt_start = (state_reg == S_MS) && !div_busy;

    mrfm_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .busy    (mul_busy),
        .product (mul_p)
    );

    mrfm_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num_in   (div_num),
        .den_in   (div_den),
        .busy     (div_busy),
        .quotient (div_q)
    );

    mrfm_serial_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .rad_in  (div_q),
        .busy    (sqrt_busy),
        .root    (sqrt_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_valid_reg && m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            win_cnt_reg   <= '0;
            sum_reg       <= '0;
            prev_np_reg   <= 1'b1;
            cross_cnt_reg <= '0;
            freq_reg      <= '0;
            freq_pend_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        cross_cnt_reg <= cross_hit ? '0 : cnt_inc;
                        freq_pend_reg <= cross_hit;
                        prev_np_reg   <= !positive;
                        state_reg     <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (acc_done) begin
                        if (freq_pend_reg) begin
                            freq_reg <= div_q[FREQ_W-1:0];
                        end
                        freq_pend_reg <= 1'b0;
                        if (win_end) begin
                            win_cnt_reg <= '0;
                            sum_reg     <= '0;
                            state_reg   <= S_MS;
                        end else begin
                            win_cnt_reg <= win_inc;
                            sum_reg     <= sum_next;
                            state_reg   <= S_IDLE;
                        end
                    end
                end
                S_MS: begin
                    if (!div_busy) begin
                        state_reg <= S_RT;
                    end
                end
                S_RT: begin
                    if (!sqrt_busy) begin
                        state_reg <= S_GM;
                    end
                end
                S_GM: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.rms_volts_q8      <= rms;
            out_reg.blackout          <= (rms < low_thr_reg);
            out_reg.surge             <= (rms > high_thr_reg);
            out_reg.frequency_centihz <= freq_reg;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_rms_volts_q8      = out_reg.rms_volts_q8;
    assign m_blackout          = out_reg.blackout;
    assign m_surge             = out_reg.surge;
    assign m_frequency_centihz = out_reg.frequency_centihz;

    // units are idle whenever a new sample may come in
    a_units_idle_on_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mul_busy && !div_busy && !sqrt_busy)
        else $error("arithmetic unit busy while accepting samples");

    a_result_from_gain_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_GM))
        else $error("result loaded outside the gain step");

    a_root_after_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_start |-> !div_busy && !mul_busy)
        else $error("root started with another unit in use");

    a_crossing_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        take && cross_hit |=> cross_cnt_reg == '0 && freq_pend_reg)
        else $error("accepted crossing did not restart the period count");

endmodule

### verif/mains_rms_and_frequency_monitor_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// mains_rms_and_frequency_monitor_tb
// Self-checking bench for the mains RMS and frequency monitor. A bit-exact
// predictor tracks the window sum, the crossing counter and the frequency
// estimate per accepted sample, and queues the expected window results. A
// checker compares every result transfer field by field. Registers are
// reprogrammed over APB between phases and read back. Stimulus covers corner
// samples, output back-pressure, triangle waveforms with noise under several
// idling mixes, and the minimum period count for a crossing.
// ============================================================================
module mains_rms_and_frequency_monitor_tb;
    import mrfm_pkg::*;

    localparam int WINDOW_BITS   = 10;
    localparam int WIN_CAP       = (1 << WINDOW_BITS) - 1;
    localparam int CLK_HALF      = 6;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [63:0] RMS_MAX = (64'd1 << THR_W) - 1;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample_mv = '0;
    logic                s_sample_valid = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [THR_W-1:0]    m_rms_volts_q8;
    logic                m_blackout;
    logic                m_surge;
    logic [FREQ_W-1:0]   m_frequency_centihz;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // predictor copy of registers and state
    logic [SAMPLE_W-1:0]    cfg_offset;
    logic [GAIN_W-1:0]      cfg_gain;
    logic [THR_W-1:0]       cfg_low_thr;
    logic [THR_W-1:0]       cfg_high_thr;
    logic [WLEN_W-1:0]      cfg_win_len;
    logic [RATE_W-1:0]      cfg_rate;
    logic [MINP_W-1:0]      cfg_min_per;
    logic [WINDOW_BITS-1:0] win_count;
    logic [SUM_W-1:0]       sq_sum;
    logic                   was_nonpos;
    logic [CNT_W-1:0]       cross_count;
    logic [FREQ_W-1:0]      freq_est;
    result_t                expected_windows[$];

    int errors = 0;
    int sender_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold_left = 0;

    mains_rms_and_frequency_monitor #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_sample_mv         (s_sample_mv),
        .s_sample_valid      (s_sample_valid),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_rms_volts_q8      (m_rms_volts_q8),
        .m_blackout          (m_blackout),
        .m_surge             (m_surge),
        .m_frequency_centihz (m_frequency_centihz),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    function automatic void monitor_reset();
        cfg_offset   = OFFSET_RST;
        cfg_gain     = GAIN_RST;
        cfg_low_thr  = LOW_THR_RST;
        cfg_high_thr = HIGH_THR_RST;
        cfg_win_len  = WIN_LEN_RST;
        cfg_rate     = RATE_RST;
        cfg_min_per  = MIN_PER_RST;
        win_count    = '0;
        sq_sum       = '0;
        was_nonpos   = 1'b1;
        cross_count  = '0;
        freq_est     = '0;
    endfunction

    function automatic void store_reg(input logic [2:0] idx, input logic [APB_DW-1:0] data);
        case (idx)
            REG_OFFSET:   cfg_offset   = data[SAMPLE_W-1:0];
            REG_GAIN:     cfg_gain     = data[GAIN_W-1:0];
            REG_LOW_THR:  cfg_low_thr  = data[THR_W-1:0];
            REG_HIGH_THR: cfg_high_thr = data[THR_W-1:0];
            REG_WIN_LEN:  cfg_win_len  = data[WLEN_W-1:0];
            REG_RATE:     cfg_rate     = data[RATE_W-1:0];
            REG_MIN_PER:  cfg_min_per  = data[MINP_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [APB_DW-1:0] reg_value(input logic [2:0] idx);
        case (idx)
            REG_OFFSET:   return APB_DW'(cfg_offset);
            REG_GAIN:     return APB_DW'(cfg_gain);
            REG_LOW_THR:  return APB_DW'(cfg_low_thr);
            REG_HIGH_THR: return APB_DW'(cfg_high_thr);
            REG_WIN_LEN:  return APB_DW'(cfg_win_len);
            REG_RATE:     return APB_DW'(cfg_rate);
            REG_MIN_PER:  return APB_DW'(cfg_min_per);
            default:      return '0;
        endcase
    endfunction

    function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [63:0] v);
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (ROOT_W'(1) << b);
            if (64'(trial) * 64'(trial) <= v) root = trial;
        end
        return root;
    endfunction

    // one accepted sample: crossing tracking, window sum, result at window end
    task automatic track_sample(input logic [SAMPLE_W-1:0] mv, input logic use_it);
        int                dev;
        logic              positive;
        logic [63:0]       mean_sq;
        logic [63:0]       gained;
        logic [ROOT_W-1:0] root;
        int unsigned       n;
        result_t           res;
        if (!use_it) return;
        dev = int'(mv) - int'(cfg_offset);
        positive = (dev > 0);
        if (cross_count != '1) cross_count++;
        if (was_nonpos && positive && cross_count > cfg_min_per) begin
            freq_est = FREQ_W'((64'(cfg_rate) * 64'd100) / 64'(cross_count));
            cross_count = '0;
        end
        was_nonpos = !positive;
        sq_sum = SUM_W'(64'(sq_sum) + 64'(dev * dev));
        win_count = win_count + 1'b1;
        n = (cfg_win_len == 0) ? 1 : ((cfg_win_len > WIN_CAP) ? WIN_CAP : cfg_win_len);
        if (win_count < n) return;
        mean_sq = (64'(sq_sum) << FRAC_W) / 64'(n);
        root = floor_sqrt(mean_sq);
        gained = (64'(root) * 64'(cfg_gain)) >> 16;
        if (gained > RMS_MAX) gained = RMS_MAX;
        res.rms_volts_q8      = THR_W'(gained);
        res.blackout          = (res.rms_volts_q8 < cfg_low_thr);
        res.surge             = (res.rms_volts_q8 > cfg_high_thr);
        res.frequency_centihz = freq_est;
        expected_windows.push_back(res);
        win_count = '0;
        sq_sum = '0;
    endtask

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // ---- APB ----
    task automatic apb_write(input logic [2:0] idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        store_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_check(input logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        compare_field("register read", reg_value(idx), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [APB_DW-1:0] with_junk(input logic [APB_DW-1:0] v, input int w);
        logic [APB_DW-1:0] keep;
        keep = (APB_DW'(1) << w) - 1;
        if ($urandom_range(0, 1) == 1) return (v & keep) | ($urandom & ~keep);
        return v;
    endfunction

    task automatic program_monitor(input logic [31:0] offset, input logic [31:0] gain,
                                   input logic [31:0] low_thr, input logic [31:0] high_thr,
                                   input logic [31:0] win_len, input logic [31:0] rate,
                                   input logic [31:0] min_per);
        apb_write(REG_OFFSET, with_junk(offset, SAMPLE_W));
        apb_check(REG_OFFSET);
        apb_write(REG_GAIN, with_junk(gain, GAIN_W));
        apb_check(REG_GAIN);
        apb_write(REG_LOW_THR, with_junk(low_thr, THR_W));
        apb_check(REG_LOW_THR);
        apb_write(REG_HIGH_THR, with_junk(high_thr, THR_W));
        apb_check(REG_HIGH_THR);
        apb_write(REG_WIN_LEN, with_junk(win_len, WLEN_W));
        apb_check(REG_WIN_LEN);
        apb_write(REG_RATE, with_junk(rate, RATE_W));
        apb_check(REG_RATE);
        apb_write(REG_MIN_PER, with_junk(min_per, MINP_W));
        apb_check(REG_MIN_PER);
    endtask

    // ---- sample channel ----
    task automatic send_sample(input logic [SAMPLE_W-1:0] mv, input logic use_it);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid        <= 1'b0;
            s_sample_mv    <= SAMPLE_W'($urandom);
            s_sample_valid <= 1'($urandom_range(0, 1));
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_mv    <= mv;
        s_sample_valid <= use_it;
        do @(posedge aclk); while (!s_ready);
        track_sample(mv, use_it);
    endtask

    // sender pauses until every window result has arrived, then lets the block go idle
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] wave_point(input int centre, input int amp,
                                                       input int period, input int idx,
                                                       input int noise);
        int ph;
        int v;
        ph = idx % period;
        if (2 * ph < period) v = centre - amp + (4 * amp * ph) / period;
        else v = centre + 3 * amp - (4 * amp * ph) / period;
        if (noise > 0) v = v + int'($urandom_range(0, 2 * noise)) - noise;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return SAMPLE_W'(v);
    endfunction

    // ---- result channel ----
    always @(posedge aclk) begin
        if (recv_hold_left > 0) begin
            m_ready <= 1'b0;
            recv_hold_left = recv_hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_windows.size() == 0) begin
                $display("%0t: result transfer with nothing expected, rms %0d freq %0d",
                         $time, m_rms_volts_q8, m_frequency_centihz);
                errors++;
            end else begin
                want = expected_windows.pop_front();
                compare_field("rms_volts_q8", want.rms_volts_q8, m_rms_volts_q8);
                compare_field("blackout", want.blackout, m_blackout);
                compare_field("surge", want.surge, m_surge);
                compare_field("frequency_centihz", want.frequency_centihz,
                              m_frequency_centihz);
            end
        end
    end

    // ---- tests ----
    task automatic test_register_defaults();
        for (int i = 0; i <= int'(REG_MIN_PER); i++) apb_check(3'(i));
    endtask

    task automatic test_corner_samples();
        sender_idle_pct = 10;
        recv_idle_pct = 10;
        // zero length window: every valid sample closes a window
        program_monitor(2048, 65535, 32'hFFFFF, 0, 0, 131071, 0);
        send_sample(12'd0, 1'b1);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd2048, 1'b1);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd2049, 1'b1);
        send_sample(12'd2047, 1'b1);
        send_sample(12'd2049, 1'b1);
        send_sample(12'd4095, 1'b1);
        settle();
        // zero gain and zero rate; crossings still tracked
        program_monitor(0, 0, 0, 32'hFFFFF, 2, 0, 1);
        send_sample(12'd0, 1'b1);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd0, 1'b1);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd1, 1'b1);
        send_sample(12'd0, 1'b1);
        settle();
        // offset at full scale: nothing is ever positive
        program_monitor(4095, 1, 1, 0, 3, 100000, 65535);
        send_sample(12'd0, 1'b1);
        send_sample(12'd4095, 1'b1);
        send_sample(12'h555, 1'b1);
        send_sample(12'hAAA, 1'b1);
        send_sample(12'd4094, 1'b1);
        send_sample(12'd4095, 1'b1);
        settle();
    endtask

    task automatic test_output_backpressure();
        sender_idle_pct = 0;
        recv_idle_pct = 0;
        program_monitor(2048, 30000, 3000, 9000, 1, 50000, 2);
        recv_hold_left = 600;
        for (int i = 0; i < 16; i++) send_sample(wave_point(2048, 900, 6, i, 0), 1'b1);
        settle();
    endtask

    task automatic run_random_traffic(input int n_items, input int tx_idle, input int rx_idle);
        int sent;
        int burst;
        int period;
        int amp;
        int centre;
        int noise;
        int gain;
        int est;
        int unsigned lo;
        int unsigned hi;
        logic use_it;
        logic [SAMPLE_W-1:0] mv;
        sender_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        sent = 0;
        while (sent < n_items) begin
            period = $urandom_range(4, 48);
            amp    = $urandom_range(0, 2047);
            centre = $urandom_range(amp, 4095 - amp);
            noise  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 8);
            case ($urandom_range(0, 9))
                0:       gain = 0;
                1:       gain = 65535;
                default: gain = $urandom_range(0, 65535);
            endcase
            est = amp * gain / 443;
            lo  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2 * est + 1);
            hi  = ($urandom_range(0, 3) == 0) ? $urandom : lo + $urandom_range(0, est + 1);
            program_monitor(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : centre,
                            gain, lo, hi,
                            ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(1, 24),
                            $urandom_range(0, 131071),
                            ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, period));
            burst = $urandom_range(30, 90);
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(0, 9) < 8) begin
                    mv = wave_point(centre, amp, period, i, noise);
                    use_it = ($urandom_range(0, 19) != 0);
                end else begin
                    mv = SAMPLE_W'($urandom);
                    use_it = 1'($urandom_range(0, 1));
                end
                send_sample(mv, use_it);
                sent++;
            end
            settle();
        end
    endtask

    // a crossing is taken only once the period count is above the minimum
    task automatic test_crossing_threshold();
        sender_idle_pct = 0;
        recv_idle_pct = 0;
        program_monitor(1000, 20000, 100, 200, 40, 50000, 16);
        for (int i = 0; i < 150; i++) begin
            if (i % 16 == 15) send_sample(12'd1001, 1'b1);
            else send_sample(SAMPLE_W'(1000 - i % 7), 1'b1);
        end
        settle();
        program_monitor(1000, 20000, 100, 200, 1, 50000, 0);
        send_sample(12'd999, 1'b1);
        send_sample(12'd1003, 1'b1);
        settle();
    endtask

    initial begin
        #100_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        monitor_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_defaults();
        test_corner_samples();
        test_output_backpressure();
        run_random_traffic(480, 20, 53);
        run_random_traffic(480, 53, 20);
        run_random_traffic(480, 0, 0);
        test_crossing_threshold();
        settle();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/mrfm_pkg.sv
rtl/mrfm_serial_mul.sv
rtl/mrfm_serial_div.sv
rtl/mrfm_serial_sqrt.sv
rtl/mains_rms_and_frequency_monitor.sv
verif/mains_rms_and_frequency_monitor_tb.sv
